// ===== rtl/mrfr_pkg.sv =====
package mrfr_pkg;

  localparam int LEN_W  = 13;
  localparam int SUB_W  = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 13;

  localparam int RING_RESET  = 4096;
  localparam int SLOTS_RESET = 256;
  localparam int RING_MIN    = 1;
  localparam int SLOTS_MIN   = 4;

  localparam logic CFG_RING_SIZE   = 1'b0;
  localparam logic CFG_FRAME_SLOTS = 1'b1;

  localparam logic [ACT_W-1:0] ACT_WRITE_START = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_BYTE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADD         = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEN    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_DATA    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TOO_SMALL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_SUB    = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXISTS     = 3'd5;
  localparam logic [STAT_W-1:0] ST_NO_WRITE   = 3'd6;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd7;

  // subscriber table commands
  typedef struct packed {
    logic add;
    logic remove;
    logic step;
    logic step_last;
    logic drop;
    logic flush;
  } rt_cmd_t;

endpackage

// ===== rtl/mrfr_store.sv =====
module mrfr_store #(
  parameter int DATA_DEPTH = 4096,
  parameter int SLOT_DEPTH = 256,
  parameter int AW         = 12,
  parameter int LW         = 8
) (
  input  logic                        clk,
  input  logic                        d_we,
  input  logic                        d_re,
  input  logic [AW-1:0]               d_addr,
  input  logic [mrfr_pkg::BYTE_W-1:0] d_wdata,
  output logic [mrfr_pkg::BYTE_W-1:0] d_rdata,
  input  logic                        e_we,
  input  logic                        e_re,
  input  logic [LW-1:0]               e_addr,
  input  logic [AW-1:0]               e_wdata,
  output logic [AW-1:0]               e_rdata
);

  logic [mrfr_pkg::BYTE_W-1:0] data_mem [DATA_DEPTH];
  logic [AW-1:0]               end_mem  [SLOT_DEPTH];
  logic [mrfr_pkg::BYTE_W-1:0] d_rdata_r;
  logic [AW-1:0]               e_rdata_r;

  always_ff @(posedge clk) begin
    if (d_we) begin
      data_mem[d_addr] <= d_wdata;
    end
    if (d_re) begin
      d_rdata_r <= data_mem[d_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      end_mem[e_addr] <= e_wdata;
    end
    if (e_re) begin
      e_rdata_r <= end_mem[e_addr];
    end
  end

  assign d_rdata = d_rdata_r;
  assign e_rdata = e_rdata_r;

endmodule

// ===== rtl/mrfr_reader_table.sv =====
module mrfr_reader_table #(
  parameter int READERS = 8,
  parameter int AW      = 12,
  parameter int LW      = 8,
  parameter int RW      = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrfr_pkg::rt_cmd_t          cmd,
  input  logic [RW-1:0]              sel,
  input  logic [AW-1:0]              set_pos,
  input  logic [LW-1:0]              set_slot,
  input  logic [LW-1:0]              match_slot,
  output logic                       sel_valid,
  output logic [AW-1:0]              sel_pos,
  output logic [LW-1:0]              sel_slot,
  output logic                       sel_mid,
  output logic [mrfr_pkg::CNT_W-1:0] sel_lost,
  output logic                       hold_any
);

  logic                       valid_r [READERS];
  logic [AW-1:0]              pos_r   [READERS];
  logic [LW-1:0]              slot_r  [READERS];
  logic                       mid_r   [READERS];
  logic [mrfr_pkg::CNT_W-1:0] lost_r  [READERS];
  logic [READERS-1:0]         at_match;

  always_comb begin
    for (int i = 0; i < READERS; i++) begin
      at_match[i] = valid_r[i] && (slot_r[i] == match_slot);
    end
  end

  assign hold_any  = |at_match;
  assign sel_valid = valid_r[sel];
  assign sel_pos   = pos_r[sel];
  assign sel_slot  = slot_r[sel];
  assign sel_mid   = mid_r[sel];
  assign sel_lost  = lost_r[sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < READERS; i++) begin
        valid_r[i] <= 1'b0;
        pos_r[i]   <= '0;
        slot_r[i]  <= '0;
        mid_r[i]   <= 1'b0;
        lost_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < READERS; i++) begin
        if (cmd.flush) begin
          pos_r[i]  <= '0;
          slot_r[i] <= '0;
          mid_r[i]  <= 1'b0;
        end else if (cmd.drop && at_match[i]) begin
          // forced drop moves the subscriber to the new oldest frame
          slot_r[i] <= set_slot;
          pos_r[i]  <= set_pos;
          mid_r[i]  <= 1'b0;
          if (lost_r[i] != '1) begin
            lost_r[i] <= lost_r[i] + 1'b1;
          end
        end else if (RW'(i) == sel) begin
          if (cmd.add) begin
            valid_r[i] <= 1'b1;
            pos_r[i]   <= set_pos;
            slot_r[i]  <= set_slot;
            mid_r[i]   <= 1'b0;
            lost_r[i]  <= '0;
          end else if (cmd.remove) begin
            valid_r[i] <= 1'b0;
            mid_r[i]   <= 1'b0;
          end else if (cmd.step) begin
            pos_r[i] <= set_pos;
            mid_r[i] <= !cmd.step_last;
            if (cmd.step_last) begin
              slot_r[i] <= set_slot;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/multi_reader_frame_ring_top.sv =====
// Multi-reader frame ring with drop-oldest policy.
// Input channel (in_valid / in_stall) carries one command word: write start,
// write byte, read byte, add or remove a subscriber. Each accepted word gives
// exactly one result word on the output channel (out_valid / out_stall).
// Path through the sequencer: table commands, rejected requests and a write
// byte that is not the last go from execute to the result state. An accepted
// write start adds the space check and a drop step per frame it has to drop,
// the last byte of a frame the close state, a read byte the frame-end read,
// a start read unless the frame is the oldest, and the size check. A read
// ending a frame or a remove adds the release check and a step per release.
// A new word is taken only back in the idle state: every word passes through
// the idle, execute and result states of the sequencer, and the drop and
// release walks read the frame-end memory one entry at a time.
// The next command word is taken while a result still sits in the output
// register; the sequencer holds in its result state while that register is
// full and out_stall is high.
// cfg_wr_en writes ring_size (index 0) or frame_slots (index 1), clamped to
// the supported range, and flushes the rings; subscribers stay registered.
// Reset (rst_n low, synchronous) empties the rings, clears every subscriber
// and the counters. The data and frame-end memories are not cleared.
module multi_reader_frame_ring_top #(
  parameter int DATA_DEPTH = 4096,
  parameter int SLOT_DEPTH = 256,
  parameter int READERS    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [mrfr_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mrfr_pkg::ACT_W-1:0]  in_action,
  input  logic [mrfr_pkg::SUB_W-1:0]  in_subscriber_slot,
  input  logic [mrfr_pkg::LEN_W-1:0]  in_frame_length,
  input  logic [mrfr_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [mrfr_pkg::LEN_W-1:0]  in_read_capacity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mrfr_pkg::STAT_W-1:0] out_status,
  output logic [mrfr_pkg::BYTE_W-1:0] out_read_byte,
  output logic                        out_last_of_frame,
  output logic [mrfr_pkg::LEN_W-1:0]  out_frame_size,
  output logic [mrfr_pkg::CNT_W-1:0]  out_lost_count,
  output logic [mrfr_pkg::CNT_W-1:0]  out_dropped_total,
  output logic [mrfr_pkg::CNT_W-1:0]  out_released_total
);

  localparam int AW = $clog2(DATA_DEPTH);
  localparam int SW = $clog2(DATA_DEPTH + 1);
  localparam int LW = $clog2(SLOT_DEPTH);
  localparam int FW = $clog2(SLOT_DEPTH + 1);
  localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int CW = (SW > mrfr_pkg::LEN_W) ? SW : mrfr_pkg::LEN_W;
  localparam int RING_RST  = (DATA_DEPTH < mrfr_pkg::RING_RESET) ? DATA_DEPTH
                                                                 : mrfr_pkg::RING_RESET;
  localparam int SLOTS_RST = (SLOT_DEPTH < mrfr_pkg::SLOTS_RESET) ? SLOT_DEPTH
                                                                  : mrfr_pkg::SLOTS_RESET;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_WB_CLOSE = 4'd2;
  localparam logic [3:0] S_WS_CHECK = 4'd3;
  localparam logic [3:0] S_DROP     = 4'd4;
  localparam logic [3:0] S_RD_END   = 4'd5;
  localparam logic [3:0] S_RD_START = 4'd6;
  localparam logic [3:0] S_RD_CHK   = 4'd7;
  localparam logic [3:0] S_REL      = 4'd8;
  localparam logic [3:0] S_REL_DROP = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  function automatic logic [SW-1:0] span_f(logic [SW-1:0] from, logic [SW-1:0] to,
                                           logic [SW-1:0] rs);
    logic [SW-1:0] d;
    if (to >= from) d = to - from;
    else d = rs - from + to;
    if (d == '0) d = rs;
    return d;
  endfunction

  function automatic logic [AW-1:0] pos_inc(logic [AW-1:0] p, logic [SW-1:0] rs);
    logic [SW-1:0] q;
    q = SW'(p) + 1'b1;
    return (q == rs) ? '0 : AW'(q);
  endfunction

  function automatic logic [LW-1:0] slot_inc(logic [LW-1:0] s, logic [FW-1:0] n);
    logic [FW-1:0] q;
    q = FW'(s) + 1'b1;
    return (q == n) ? '0 : LW'(q);
  endfunction

  function automatic logic [LW-1:0] slot_dec(logic [LW-1:0] s, logic [FW-1:0] n);
    logic [FW-1:0] q;
    q = n - 1'b1;
    return (s == '0) ? LW'(q) : s - 1'b1;
  endfunction

  logic [3:0]                  state_r, state_nxt;
  logic [SW-1:0]               ring_size_r, ring_size_nxt;
  logic [FW-1:0]               frame_slots_r, frame_slots_nxt;
  logic [LW-1:0]               slot_head_r, slot_head_nxt;
  logic [LW-1:0]               slot_tail_r, slot_tail_nxt;
  logic [AW-1:0]               byte_head_r, byte_head_nxt;
  logic [AW-1:0]               byte_tail_r, byte_tail_nxt;
  logic [AW-1:0]               wcur_r, wcur_nxt;
  logic [mrfr_pkg::LEN_W-1:0]  wrem_r, wrem_nxt;
  logic [SW-1:0]               used_r, used_nxt;
  logic [LW-1:0]               held_r, held_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  dropped_r, dropped_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  released_r, released_nxt;

  logic [mrfr_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [mrfr_pkg::SUB_W-1:0]  sub_r, sub_nxt;
  logic [mrfr_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [mrfr_pkg::BYTE_W-1:0] dbyte_r, dbyte_nxt;
  logic [mrfr_pkg::LEN_W-1:0]  cap_r, cap_nxt;
  logic [AW-1:0]               rd_end_r, rd_end_nxt;
  logic [AW-1:0]               rd_start_r, rd_start_nxt;
  logic [mrfr_pkg::BYTE_W-1:0] rd_byte_r, rd_byte_nxt;

  logic [mrfr_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [mrfr_pkg::BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic                        res_last_r, res_last_nxt;
  logic [mrfr_pkg::LEN_W-1:0]  res_fsz_r, res_fsz_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  res_lost_r, res_lost_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mrfr_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [mrfr_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [mrfr_pkg::LEN_W-1:0]  out_fsz_r, out_fsz_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  out_lost_r, out_lost_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  out_drop_r, out_drop_nxt;
  logic [mrfr_pkg::CNT_W-1:0]  out_rel_r, out_rel_nxt;

  logic                        d_we, d_re;
  logic [AW-1:0]               d_addr;
  logic [mrfr_pkg::BYTE_W-1:0] d_wdata, d_rdata;
  logic                        e_we, e_re;
  logic [LW-1:0]               e_addr;
  logic [AW-1:0]               e_wdata, e_rdata;

  mrfr_pkg::rt_cmd_t           tcmd;
  logic [AW-1:0]               tpos;
  logic [LW-1:0]               tslot;
  logic                        t_valid, t_mid, t_hold;
  logic [AW-1:0]               t_pos;
  logic [LW-1:0]               t_slot;
  logic [mrfr_pkg::CNT_W-1:0]  t_lost;

  logic                        sub_ok;
  logic                        out_free;
  logic [31:0]                 cfg_v;
  logic [SW-1:0]               cfg_ring;
  logic [FW-1:0]               cfg_slots;
  logic [SW-1:0]               drop_sz;
  logic [SW-1:0]               close_sz;
  logic [SW-1:0]               rd_sz;
  logic [AW-1:0]               rd_pnext;
  logic [LW-1:0]               tail_inc;

  assign sub_ok   = 32'(sub_r) < 32'(READERS);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_v    = 32'(cfg_wdata);
  assign cfg_ring = (cfg_v < 32'(mrfr_pkg::RING_MIN)) ? SW'(mrfr_pkg::RING_MIN) :
                    (cfg_v > 32'(DATA_DEPTH)) ? SW'(DATA_DEPTH) : SW'(cfg_v);
  assign cfg_slots = (cfg_v < 32'(mrfr_pkg::SLOTS_MIN)) ? FW'(mrfr_pkg::SLOTS_MIN) :
                     (cfg_v > 32'(SLOT_DEPTH)) ? FW'(SLOT_DEPTH) : FW'(cfg_v);
  assign drop_sz  = span_f(SW'(byte_tail_r), SW'(e_rdata), ring_size_r);
  assign close_sz = span_f(SW'(byte_head_r), SW'(wcur_r), ring_size_r);
  assign rd_sz    = span_f(SW'(rd_start_r), SW'(rd_end_r), ring_size_r);
  assign rd_pnext = pos_inc(t_pos, ring_size_r);
  assign tail_inc = slot_inc(slot_tail_r, frame_slots_r);

  mrfr_store #(
    .DATA_DEPTH(DATA_DEPTH),
    .SLOT_DEPTH(SLOT_DEPTH),
    .AW        (AW),
    .LW        (LW)
  ) u_store (
    .clk    (clk),
    .d_we   (d_we),
    .d_re   (d_re),
    .d_addr (d_addr),
    .d_wdata(d_wdata),
    .d_rdata(d_rdata),
    .e_we   (e_we),
    .e_re   (e_re),
    .e_addr (e_addr),
    .e_wdata(e_wdata),
    .e_rdata(e_rdata)
  );

  mrfr_reader_table #(
    .READERS(READERS),
    .AW     (AW),
    .LW     (LW),
    .RW     (RW)
  ) u_readers (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (tcmd),
    .sel       (RW'(sub_r)),
    .set_pos   (tpos),
    .set_slot  (tslot),
    .match_slot(slot_tail_r),
    .sel_valid (t_valid),
    .sel_pos   (t_pos),
    .sel_slot  (t_slot),
    .sel_mid   (t_mid),
    .sel_lost  (t_lost),
    .hold_any  (t_hold)
  );

  always_comb begin
    state_nxt       = state_r;
    ring_size_nxt   = ring_size_r;
    frame_slots_nxt = frame_slots_r;
    slot_head_nxt   = slot_head_r;
    slot_tail_nxt   = slot_tail_r;
    byte_head_nxt   = byte_head_r;
    byte_tail_nxt   = byte_tail_r;
    wcur_nxt        = wcur_r;
    wrem_nxt        = wrem_r;
    used_nxt        = used_r;
    held_nxt        = held_r;
    dropped_nxt     = dropped_r;
    released_nxt    = released_r;
    act_nxt         = act_r;
    sub_nxt         = sub_r;
    len_nxt         = len_r;
    dbyte_nxt       = dbyte_r;
    cap_nxt         = cap_r;
    rd_end_nxt      = rd_end_r;
    rd_start_nxt    = rd_start_r;
    rd_byte_nxt     = rd_byte_r;
    res_status_nxt  = res_status_r;
    res_byte_nxt    = res_byte_r;
    res_last_nxt    = res_last_r;
    res_fsz_nxt     = res_fsz_r;
    res_lost_nxt    = res_lost_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    out_fsz_nxt     = out_fsz_r;
    out_lost_nxt    = out_lost_r;
    out_drop_nxt    = out_drop_r;
    out_rel_nxt     = out_rel_r;
    d_we    = 1'b0;
    d_re    = 1'b0;
    d_addr  = wcur_r;
    d_wdata = dbyte_r;
    e_we    = 1'b0;
    e_re    = 1'b0;
    e_addr  = slot_tail_r;
    e_wdata = wcur_r;
    tcmd    = '0;
    tpos    = byte_head_r;
    tslot   = slot_head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          sub_nxt   = in_subscriber_slot;
          len_nxt   = in_frame_length;
          dbyte_nxt = in_data_byte;
          cap_nxt   = in_read_capacity;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = mrfr_pkg::ST_OK;
        res_byte_nxt   = '0;
        res_last_nxt   = 1'b0;
        res_fsz_nxt    = '0;
        res_lost_nxt   = '0;
        state_nxt      = S_DONE;
        case (act_r)
          mrfr_pkg::ACT_WRITE_START: begin
            if (len_r == '0 || CW'(len_r) > CW'(ring_size_r)) begin
              res_status_nxt = mrfr_pkg::ST_BAD_LEN;
            end else begin
              state_nxt = S_WS_CHECK;
            end
          end
          mrfr_pkg::ACT_WRITE_BYTE: begin
            if (wrem_r == '0) begin
              res_status_nxt = mrfr_pkg::ST_NO_WRITE;
            end else begin
              d_we        = 1'b1;
              wcur_nxt    = pos_inc(wcur_r, ring_size_r);
              wrem_nxt    = wrem_r - 1'b1;
              res_fsz_nxt = wrem_r - 1'b1;
              if (wrem_r == mrfr_pkg::LEN_W'(1)) begin
                state_nxt = S_WB_CLOSE;
              end
            end
          end
          mrfr_pkg::ACT_READ: begin
            if (!sub_ok || !t_valid) begin
              res_status_nxt = mrfr_pkg::ST_NOT_SUB;
            end else begin
              res_lost_nxt = t_lost;
              if (t_slot == slot_head_r) begin
                res_status_nxt = mrfr_pkg::ST_NO_DATA;
              end else begin
                e_re      = 1'b1;
                e_addr    = t_slot;
                d_re      = 1'b1;
                d_addr    = t_pos;
                state_nxt = S_RD_END;
              end
            end
          end
          mrfr_pkg::ACT_ADD: begin
            if (!sub_ok) begin
              res_status_nxt = mrfr_pkg::ST_TABLE_FULL;
            end else if (t_valid) begin
              res_status_nxt = mrfr_pkg::ST_EXISTS;
              res_lost_nxt   = t_lost;
            end else begin
              tcmd.add = 1'b1;
            end
          end
          mrfr_pkg::ACT_REMOVE: begin
            if (!sub_ok || !t_valid) begin
              res_status_nxt = mrfr_pkg::ST_NOT_SUB;
            end else begin
              res_lost_nxt = t_lost;
              tcmd.remove  = 1'b1;
              state_nxt    = S_REL;
            end
          end
          default: ;
        endcase
      end
      S_WB_CLOSE: begin
        // last byte in: publish the frame end
        used_nxt      = used_r + close_sz;
        e_we          = 1'b1;
        e_addr        = slot_head_r;
        slot_head_nxt = slot_inc(slot_head_r, frame_slots_r);
        held_nxt      = held_r + 1'b1;
        byte_head_nxt = wcur_r;
        state_nxt     = S_DONE;
      end
      S_WS_CHECK: begin
        if (FW'(held_r) >= frame_slots_r - 1'b1 ||
            CW'(ring_size_r - used_r) < CW'(len_r)) begin
          if (held_r == '0) begin
            byte_tail_nxt = byte_head_r;
            used_nxt      = '0;
          end else begin
            e_re      = 1'b1;
            state_nxt = S_DROP;
          end
        end else begin
          wcur_nxt    = byte_head_r;
          wrem_nxt    = len_r;
          res_fsz_nxt = len_r;
          state_nxt   = S_DONE;
        end
      end
      S_DROP, S_REL_DROP: begin
        byte_tail_nxt = e_rdata;
        slot_tail_nxt = tail_inc;
        held_nxt      = held_r - 1'b1;
        used_nxt      = (used_r >= drop_sz) ? used_r - drop_sz : '0;
        if (state_r == S_DROP) begin
          if (dropped_r != '1) dropped_nxt = dropped_r + 1'b1;
          tcmd.drop = 1'b1;
          tslot     = tail_inc;
          tpos      = e_rdata;
          state_nxt = S_WS_CHECK;
        end else begin
          if (released_r != '1) released_nxt = released_r + 1'b1;
          state_nxt = S_REL;
        end
      end
      S_RD_END: begin
        rd_end_nxt  = e_rdata;
        rd_byte_nxt = d_rdata;
        if (t_slot == slot_tail_r) begin
          rd_start_nxt = byte_tail_r;
          state_nxt    = S_RD_CHK;
        end else begin
          // frame start is the previous frame's end
          e_re      = 1'b1;
          e_addr    = slot_dec(t_slot, frame_slots_r);
          state_nxt = S_RD_START;
        end
      end
      S_RD_START: begin
        rd_start_nxt = e_rdata;
        state_nxt    = S_RD_CHK;
      end
      S_RD_CHK: begin
        res_fsz_nxt = mrfr_pkg::LEN_W'(rd_sz);
        state_nxt   = S_DONE;
        if (!t_mid && CW'(cap_r) < CW'(rd_sz)) begin
          res_status_nxt = mrfr_pkg::ST_TOO_SMALL;
        end else begin
          res_byte_nxt = rd_byte_r;
          tcmd.step    = 1'b1;
          tpos         = rd_pnext;
          tslot        = slot_inc(t_slot, frame_slots_r);
          if (rd_pnext == rd_end_r) begin
            res_last_nxt   = 1'b1;
            tcmd.step_last = 1'b1;
            state_nxt      = S_REL;
          end
        end
      end
      S_REL: begin
        if (held_r != '0 && !t_hold) begin
          e_re      = 1'b1;
          state_nxt = S_REL_DROP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_byte_nxt   = res_byte_r;
          out_last_nxt   = res_last_r;
          out_fsz_nxt    = res_fsz_r;
          out_lost_nxt   = res_lost_r;
          out_drop_nxt   = dropped_r;
          out_rel_nxt    = released_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr_en) begin
      if (cfg_index == mrfr_pkg::CFG_RING_SIZE) ring_size_nxt = cfg_ring;
      if (cfg_index == mrfr_pkg::CFG_FRAME_SLOTS) frame_slots_nxt = cfg_slots;
      slot_head_nxt = '0;
      slot_tail_nxt = '0;
      byte_head_nxt = '0;
      byte_tail_nxt = '0;
      wcur_nxt      = '0;
      wrem_nxt      = '0;
      used_nxt      = '0;
      held_nxt      = '0;
      tcmd.flush    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ring_size_r   <= SW'(RING_RST);
      frame_slots_r <= FW'(SLOTS_RST);
      slot_head_r   <= '0;
      slot_tail_r   <= '0;
      byte_head_r   <= '0;
      byte_tail_r   <= '0;
      wcur_r        <= '0;
      wrem_r        <= '0;
      used_r        <= '0;
      held_r        <= '0;
      dropped_r     <= '0;
      released_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ring_size_r   <= ring_size_nxt;
      frame_slots_r <= frame_slots_nxt;
      slot_head_r   <= slot_head_nxt;
      slot_tail_r   <= slot_tail_nxt;
      byte_head_r   <= byte_head_nxt;
      byte_tail_r   <= byte_tail_nxt;
      wcur_r        <= wcur_nxt;
      wrem_r        <= wrem_nxt;
      used_r        <= used_nxt;
      held_r        <= held_nxt;
      dropped_r     <= dropped_nxt;
      released_r    <= released_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    sub_r        <= sub_nxt;
    len_r        <= len_nxt;
    dbyte_r      <= dbyte_nxt;
    cap_r        <= cap_nxt;
    rd_end_r     <= rd_end_nxt;
    rd_start_r   <= rd_start_nxt;
    rd_byte_r    <= rd_byte_nxt;
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    res_last_r   <= res_last_nxt;
    res_fsz_r    <= res_fsz_nxt;
    res_lost_r   <= res_lost_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_fsz_r    <= out_fsz_nxt;
    out_lost_r   <= out_lost_nxt;
    out_drop_r   <= out_drop_nxt;
    out_rel_r    <= out_rel_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_byte      = out_byte_r;
  assign out_last_of_frame  = out_last_r;
  assign out_frame_size     = out_fsz_r;
  assign out_lost_count     = out_lost_r;
  assign out_dropped_total  = out_drop_r;
  assign out_released_total = out_rel_r;

  a_held_fits: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(held_r) < frame_slots_r)
    else $error("frame count reached the slot ring size");

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(byte_head_r) < ring_size_r && SW'(byte_tail_r) < ring_size_r)
    else $error("byte pointer outside the ring");

  a_used_fits: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= ring_size_r)
    else $error("used bytes exceed ring size");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not loaded into output register");

endmodule

// ===== tb/sv/tb_multi_reader_frame_ring_top.sv =====
`timescale 1ns / 100ps

module tb_multi_reader_frame_ring_top;

  localparam int DATA_DEPTH = 4096;
  localparam int SLOT_DEPTH = 256;
  localparam int READERS    = 8;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int IDLE_LIMIT = 8000;
  localparam int DRAIN_WAIT = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [mrfr_pkg::ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [mrfr_pkg::ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [mrfr_pkg::STAT_W-1:0] status;
    logic [mrfr_pkg::BYTE_W-1:0] rd_byte;
    logic                        last;
    logic [mrfr_pkg::LEN_W-1:0]  fsize;
    logic [mrfr_pkg::CNT_W-1:0]  lost;
    logic [mrfr_pkg::CNT_W-1:0]  dropped;
    logic [mrfr_pkg::CNT_W-1:0]  released;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [mrfr_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mrfr_pkg::ACT_W-1:0] in_action = '0;
  logic [mrfr_pkg::SUB_W-1:0] in_subscriber_slot = '0;
  logic [mrfr_pkg::LEN_W-1:0] in_frame_length = '0;
  logic [mrfr_pkg::BYTE_W-1:0] in_data_byte = '0;
  logic [mrfr_pkg::LEN_W-1:0] in_read_capacity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mrfr_pkg::STAT_W-1:0] out_status;
  logic [mrfr_pkg::BYTE_W-1:0] out_read_byte;
  logic out_last_of_frame;
  logic [mrfr_pkg::LEN_W-1:0] out_frame_size;
  logic [mrfr_pkg::CNT_W-1:0] out_lost_count;
  logic [mrfr_pkg::CNT_W-1:0] out_dropped_total;
  logic [mrfr_pkg::CNT_W-1:0] out_released_total;

  multi_reader_frame_ring_top #(
    .DATA_DEPTH(DATA_DEPTH), .SLOT_DEPTH(SLOT_DEPTH), .READERS(READERS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_subscriber_slot(in_subscriber_slot), .in_frame_length(in_frame_length),
    .in_data_byte(in_data_byte), .in_read_capacity(in_read_capacity),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_read_byte(out_read_byte), .out_last_of_frame(out_last_of_frame),
    .out_frame_size(out_frame_size), .out_lost_count(out_lost_count),
    .out_dropped_total(out_dropped_total), .out_released_total(out_released_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ring model state
  int unsigned ring_bytes, slot_count;
  logic [7:0] data_mem [DATA_DEPTH];
  int unsigned end_mem [SLOT_DEPTH];
  int unsigned s_head, s_tail, b_head, b_tail, wr_ptr, wr_left, used, held;
  logic [31:0] drops, releases;
  bit sub_on [READERS];
  int unsigned sub_pos [READERS];
  int unsigned sub_frame [READERS];
  bit sub_mid [READERS];
  logic [31:0] sub_lost [READERS];

  ring_result_t pending_q[$];
  int fail_cnt = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [mrfr_pkg::SUB_W-1:0] rnd_sub();
    return mrfr_pkg::SUB_W'($urandom);
  endfunction

  function automatic logic [mrfr_pkg::LEN_W-1:0] rnd_len();
    return mrfr_pkg::LEN_W'($urandom);
  endfunction

  function automatic logic [mrfr_pkg::BYTE_W-1:0] rnd_byte();
    return mrfr_pkg::BYTE_W'($urandom);
  endfunction

  function automatic int unsigned ring_span(int unsigned from, int unsigned to);
    int unsigned d;
    d = (to >= from) ? to - from : ring_bytes - from + to;
    return (d == 0) ? ring_bytes : d;
  endfunction

  function automatic void flush_ring();
    s_head = 0; s_tail = 0; b_head = 0; b_tail = 0;
    wr_ptr = 0; wr_left = 0; used = 0; held = 0;
    for (int i = 0; i < READERS; i++) begin
      sub_pos[i] = 0; sub_frame[i] = 0; sub_mid[i] = 0;
    end
  endfunction

  function automatic void drop_oldest(bit forced);
    int unsigned old, fend, sz;
    if (held == 0) begin
      b_tail = b_head;
      used = 0;
      return;
    end
    old = s_tail;
    fend = end_mem[SLOT_AW'(old)];
    sz = ring_span(b_tail, fend);
    b_tail = fend;
    s_tail = (s_tail + 1) % slot_count;
    held--;
    used = (used >= sz) ? used - sz : 0;
    if (forced) begin
      drops = sat_inc(drops);
      for (int i = 0; i < READERS; i++) begin
        if (sub_on[i] && sub_frame[i] == old) begin
          sub_frame[i] = s_tail;
          sub_pos[i] = b_tail;
          sub_mid[i] = 0;
          sub_lost[i] = sat_inc(sub_lost[i]);
        end
      end
    end else begin
      releases = sat_inc(releases);
    end
  endfunction

  function automatic void release_passed();
    bit blocked;
    while (held > 0) begin
      blocked = 0;
      for (int i = 0; i < READERS; i++)
        if (sub_on[i] && sub_frame[i] == s_tail) blocked = 1;
      if (blocked) return;
      drop_oldest(0);
    end
  endfunction

  function automatic ring_result_t predict_word(logic [mrfr_pkg::ACT_W-1:0] act,
                                                logic [mrfr_pkg::SUB_W-1:0] sub,
                                                logic [mrfr_pkg::LEN_W-1:0] len,
                                                logic [mrfr_pkg::BYTE_W-1:0] byt,
                                                logic [mrfr_pkg::LEN_W-1:0] cap);
    ring_result_t r;
    int unsigned rs, fend, fstart, fsz;
    r = '{mrfr_pkg::ST_OK, '0, 1'b0, '0, '0, '0, '0};
    case (act)
      mrfr_pkg::ACT_WRITE_START: begin
        if (len == 0 || 32'(len) > ring_bytes) begin
          r.status = mrfr_pkg::ST_BAD_LEN;
        end else begin
          while (held >= slot_count - 1 || ring_bytes - used < 32'(len)) drop_oldest(1);
          wr_ptr = b_head;
          wr_left = 32'(len);
          r.fsize = len;
        end
      end
      mrfr_pkg::ACT_WRITE_BYTE: begin
        if (wr_left == 0) begin
          r.status = mrfr_pkg::ST_NO_WRITE;
        end else begin
          data_mem[DATA_AW'(wr_ptr)] = byt;
          wr_ptr = (wr_ptr + 1) % ring_bytes;
          wr_left--;
          r.fsize = mrfr_pkg::LEN_W'(wr_left);
          if (wr_left == 0) begin
            used += ring_span(b_head, wr_ptr);
            end_mem[SLOT_AW'(s_head)] = wr_ptr;
            s_head = (s_head + 1) % slot_count;
            held++;
            b_head = wr_ptr;
          end
        end
      end
      mrfr_pkg::ACT_READ: begin
        if (!sub_on[sub]) begin
          r.status = mrfr_pkg::ST_NOT_SUB;
        end else begin
          rs = sub_frame[sub];
          r.lost = sub_lost[sub];
          if (rs == s_head) begin
            r.status = mrfr_pkg::ST_NO_DATA;
          end else begin
            fend = end_mem[SLOT_AW'(rs)];
            fstart = (rs == s_tail) ? b_tail
                                    : end_mem[SLOT_AW'((rs + slot_count - 1) % slot_count)];
            fsz = ring_span(fstart, fend);
            r.fsize = mrfr_pkg::LEN_W'(fsz);
            if (!sub_mid[sub] && 32'(cap) < fsz) begin
              r.status = mrfr_pkg::ST_TOO_SMALL;
            end else begin
              r.rd_byte = data_mem[DATA_AW'(sub_pos[sub])];
              sub_pos[sub] = (sub_pos[sub] + 1) % ring_bytes;
              sub_mid[sub] = 1;
              if (sub_pos[sub] == fend) begin
                r.last = 1;
                sub_mid[sub] = 0;
                sub_frame[sub] = (rs + 1) % slot_count;
                release_passed();
              end
            end
          end
        end
      end
      mrfr_pkg::ACT_ADD: begin
        if (sub_on[sub]) begin
          r.status = mrfr_pkg::ST_EXISTS;
          r.lost = sub_lost[sub];
        end else begin
          sub_on[sub] = 1;
          sub_pos[sub] = b_head;
          sub_frame[sub] = s_head;
          sub_mid[sub] = 0;
          sub_lost[sub] = 0;
        end
      end
      mrfr_pkg::ACT_REMOVE: begin
        if (!sub_on[sub]) begin
          r.status = mrfr_pkg::ST_NOT_SUB;
        end else begin
          r.lost = sub_lost[sub];
          sub_on[sub] = 0;
          sub_mid[sub] = 0;
          release_passed();
        end
      end
      default: ;
    endcase
    r.dropped = drops;
    r.released = releases;
    return r;
  endfunction

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [mrfr_pkg::ACT_W-1:0] act, logic [mrfr_pkg::SUB_W-1:0] sub,
                           logic [mrfr_pkg::LEN_W-1:0] len, logic [mrfr_pkg::BYTE_W-1:0] byt,
                           logic [mrfr_pkg::LEN_W-1:0] cap);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_action = act;
    in_subscriber_slot = sub;
    in_frame_length = len;
    in_data_byte = byt;
    in_read_capacity = cap;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.insert(pending_q.size(), predict_word(act, sub, len, byt, cap));
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [mrfr_pkg::CFG_W-1:0] val);
    in_valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == mrfr_pkg::CFG_RING_SIZE)
      ring_bytes = (32'(val) < mrfr_pkg::RING_MIN) ? mrfr_pkg::RING_MIN :
                   (32'(val) > DATA_DEPTH) ? DATA_DEPTH : 32'(val);
    else
      slot_count = (32'(val) < mrfr_pkg::SLOTS_MIN) ? mrfr_pkg::SLOTS_MIN :
                   (32'(val) > SLOT_DEPTH) ? SLOT_DEPTH : 32'(val);
    flush_ring();
  endtask

  task automatic test_directed();
    send_word(mrfr_pkg::ACT_ADD, 3'd0, '0, '0, '0);
    send_word(mrfr_pkg::ACT_ADD, 3'd0, '0, '0, '0);
    send_word(mrfr_pkg::ACT_READ, 3'd1, '0, '0, 13'h1FFF);
    send_word(mrfr_pkg::ACT_READ, 3'd0, '0, '0, 13'h1FFF);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'h11, '0);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, '0, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'd4097, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'h1FFF, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'd4096, '0, '0);
    // restart while open: abandoned, new frame in the same place
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'd3, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'h00, '0);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'hFF, '0);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'hA5, '0);
    send_word(mrfr_pkg::ACT_READ, 3'd0, '0, '0, 13'd2);
    send_word(mrfr_pkg::ACT_READ, 3'd0, '0, '0, 13'd3);
    send_word(mrfr_pkg::ACT_READ, 3'd0, '0, '0, 13'd0); // capacity ignored mid-frame
    send_word(mrfr_pkg::ACT_READ, 3'd0, '0, '0, 13'd0);
    send_word(mrfr_pkg::ACT_REMOVE, 3'd0, '0, '0, '0);
    send_word(mrfr_pkg::ACT_REMOVE, 3'd0, '0, '0, '0);
    for (int a = int'(ACT_UNUSED_FIRST); a <= int'(ACT_UNUSED_LAST); a++)
      send_word(mrfr_pkg::ACT_W'(a), 3'h7, 13'h1FFF, 8'hFF, 13'h1FFF);
  endtask

  // a frame as long as the ring, plus forced drops under a slow reader
  task automatic test_full_ring();
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd4);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd0);
    send_word(mrfr_pkg::ACT_ADD, 3'd5, '0, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'd4, '0, '0);
    for (int i = 0; i < 4; i++) send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, rnd_byte(), '0);
    send_word(mrfr_pkg::ACT_READ, 3'd5, '0, '0, 13'd4);
    send_word(mrfr_pkg::ACT_WRITE_START, 3'd0, 13'd2, '0, '0);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'h5A, '0);
    send_word(mrfr_pkg::ACT_WRITE_BYTE, 3'd0, '0, 8'hC3, '0);
    send_word(mrfr_pkg::ACT_READ, 3'd5, '0, '0, 13'd4);
    send_word(mrfr_pkg::ACT_REMOVE, 3'd5, '0, '0, '0);
  endtask

  task automatic send_frame(int unsigned len, bit cut);
    int unsigned n;
    send_word(mrfr_pkg::ACT_WRITE_START, rnd_sub(), mrfr_pkg::LEN_W'(len), rnd_byte(),
              rnd_len());
    n = cut ? $urandom_range(len) : len;
    for (int i = 0; i < n; i++)
      send_word(mrfr_pkg::ACT_WRITE_BYTE, rnd_sub(), rnd_len(), rnd_byte(), rnd_len());
  endtask

  task automatic test_random(int items);
    int sent, r, k, maxlen;
    logic [mrfr_pkg::SUB_W-1:0] sub;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      sub = rnd_sub();
      maxlen = (ring_bytes < 24) ? ring_bytes : 24;
      if (r < 30) begin
        k = ($urandom_range(19) == 0) ? ring_bytes : $urandom_range(maxlen, 1);
        if (k > 64) k = 64;
        send_frame(k, $urandom_range(9) == 0);
        sent += k + 1;
      end else if (r < 62) begin
        k = $urandom_range(20, 1);
        for (int i = 0; i < k; i++)
          send_word(mrfr_pkg::ACT_READ, sub, rnd_len(), rnd_byte(),
                    ($urandom_range(4) == 0) ? mrfr_pkg::LEN_W'($urandom_range(20))
                                             : rnd_len());
        sent += k;
      end else if (r < 78) begin
        send_word(mrfr_pkg::ACT_ADD, sub, rnd_len(), rnd_byte(), rnd_len());
        sent++;
      end else if (r < 86) begin
        send_word(mrfr_pkg::ACT_REMOVE, sub, rnd_len(), rnd_byte(), rnd_len());
        sent++;
      end else begin
        send_word(mrfr_pkg::ACT_W'($urandom), rnd_sub(), rnd_len(), rnd_byte(), rnd_len());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req++;
    @(negedge clk);
    for (int i = 0; i < 30; i++)
      send_word(($urandom_range(1) != 0) ? mrfr_pkg::ACT_ADD : mrfr_pkg::ACT_READ,
                rnd_sub(), rnd_len(), rnd_byte(), rnd_len());
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    ring_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status); fail_cnt++;
        end
        if (out_read_byte !== e.rd_byte) begin
          $error("read_byte: expected %0h actual %0h", e.rd_byte, out_read_byte); fail_cnt++;
        end
        if (out_last_of_frame !== e.last) begin
          $error("last_of_frame: expected %0d actual %0d", e.last, out_last_of_frame);
          fail_cnt++;
        end
        if (out_frame_size !== e.fsize) begin
          $error("frame_size: expected %0d actual %0d", e.fsize, out_frame_size); fail_cnt++;
        end
        if (out_lost_count !== e.lost) begin
          $error("lost_count: expected %0d actual %0d", e.lost, out_lost_count); fail_cnt++;
        end
        if (out_dropped_total !== e.dropped) begin
          $error("dropped_total: expected %0d actual %0d", e.dropped, out_dropped_total);
          fail_cnt++;
        end
        if (out_released_total !== e.released) begin
          $error("released_total: expected %0d actual %0d", e.released, out_released_total);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    ring_bytes = mrfr_pkg::RING_RESET;
    slot_count = mrfr_pkg::SLOTS_RESET;
    flush_ring();
    drops = 0;
    releases = 0;
    for (int i = 0; i < READERS; i++) begin
      sub_on[i] = 0;
      sub_lost[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_pct = 11; recv_pct = 54;
    test_directed();
    test_full_ring();

    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd64);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd8);
    test_random(250);
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd1);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd5);
    test_random(100);

    send_pct = 54; recv_pct = 11;
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'h1FFF);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd511);
    test_random(250);
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd16);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd4);
    test_random(200);

    send_pct = 0; recv_pct = 0;
    test_backpressure();
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd40);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd256);
    test_random(250);
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd0);
    test_random(50);
    write_reg(mrfr_pkg::CFG_RING_SIZE, 13'd4096);
    write_reg(mrfr_pkg::CFG_FRAME_SLOTS, 13'd6);
    test_random(200);

    in_valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
